FILE: hw/rtl/tvs_pkg.sv
// shared types, codes and constants of the teleop velocity shaper
`default_nettype none

package tvs_pkg;

  // input word modes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_MANUAL = 3'd1;
  localparam logic [2:0] MODE_GEAR   = 3'd2;
  localparam logic [2:0] MODE_PROC   = 3'd3;
  localparam logic [2:0] MODE_TWIST  = 3'd4;

  // manual command codes
  localparam logic [2:0] CMD_LIN_UP = 3'd1;
  localparam logic [2:0] CMD_LIN_DN = 3'd2;
  localparam logic [2:0] CMD_ANG_DN = 3'd3;
  localparam logic [2:0] CMD_ANG_UP = 3'd4;
  localparam logic [2:0] CMD_ZERO   = 3'd5;

  // gears
  localparam logic [1:0] GEAR_AUTO   = 2'd0;
  localparam logic [1:0] GEAR_MANUAL = 2'd1;

  // register indexes
  localparam logic [2:0] CFG_WAIT_TICKS   = 3'd0;
  localparam logic [2:0] CFG_RAMP_TICKS   = 3'd1;
  localparam logic [2:0] CFG_RADIUS_MM    = 3'd2;
  localparam logic [2:0] CFG_LINEAR_STEP  = 3'd3;
  localparam logic [2:0] CFG_ANGULAR_STEP = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // arithmetic sizes
  localparam int VEL_W     = 16;
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ROOT_W    = 26;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int DIV_W     = 26;
  localparam int DVS_W     = 14;
  localparam int DIV_STEPS = 2;
  localparam int SQ_STEPS  = 2;
  localparam int SPEED_W   = 13;

  // scale constants: mm to um and half a cm/s in um/s
  localparam int K_LIN     = 1000;
  localparam int K_HALF    = 5000;
  localparam int SPEED_MAX = 8191;

  // rounding to cm/s: drop four bits (divide by 16), then divide by 625 as a
  // multiply by 2^32/625 rounded up, exact for every root the block can produce
  localparam int RND_SHIFT = 4;
  localparam int RND_POS   = 32;
  localparam int RND_RECIP = 6871948;
  localparam int RND_SUM_W = ROOT_W + 1;
  localparam int RND_Y_W   = RND_SUM_W - RND_SHIFT;
  localparam int SPD_HI_W  = PROD_W - RND_POS;

  typedef struct packed {
    logic [2:0]        mode;
    logic [2:0]        command_code;
    logic [1:0]        gear_value;
    logic              process_busy;
    logic signed [15:0] measured_linear;
    logic signed [15:0] measured_angular;
  } tvs_in_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               publish_twist;
    logic [12:0]        speed_cms;
  } tvs_out_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RAMP,
    MUL_LIN,
    MUL_ANG,
    MUL_SQ,
    MUL_RND
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_RAMP,
    ST_RMUL,
    ST_RDIV_GO,
    ST_RDIV,
    ST_RWB,
    ST_SLIN,
    ST_SLSQ,
    ST_SANG,
    ST_SASQ,
    ST_SQRT_GO,
    ST_SQRT,
    ST_RND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     accept;
    logic     tick_upd;
    logic     ramp_zero;
    logic     ramp_wb;
    mul_op_t  mul_op;
    logic     acc_load;
    logic     div_start;
    logic     sqrt_start;
    logic     emit;
  } tvs_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic ramping;
    logic ramp_end;
    logic div_busy;
    logic sqrt_busy;
  } tvs_stat_t;

  // clamp an 18 bit signed sum to the 16 bit velocity range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // magnitude of a signed velocity, 32768 included
  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] u;
    u = v;
    return u[15] ? (~u + 16'd1) : u;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tvs_div.sv
// iterative restoring divider, two quotient bits per cycle
`default_nettype none

module tvs_div import tvs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient
);

  localparam int ITER  = DIV_W / DIV_STEPS;
  localparam int CNT_W = $clog2(ITER + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;

  // DIV_STEPS shift-subtract steps per cycle
  always_comb begin
    logic [DVS_W:0] rem_t;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_t   = {rem_nxt, dvd_nxt[DIV_W-1]};
      dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_nxt    = DVS_W'(rem_t - {1'b0, dvs_r});
        dvd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = rem_t[DVS_W-1:0];
      end
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ITER);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tvs_sqrt.sv
// iterative digit-by-digit integer square root, two root bits per cycle
`default_nettype none

module tvs_sqrt import tvs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] radicand,
  output logic                  busy,
  output logic [ROOT_W-1:0]     root
);

  localparam int ITER  = ROOT_W / SQ_STEPS;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam int REM_W = ROOT_W + 2;

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    logic [REM_W+1:0] rem_t;
    logic [REM_W+1:0] trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem_t   = {rem_nxt, rad_nxt[RAD_W-1 -: 2]};
      trial   = {2'b00, root_nxt, 2'b01};
      rad_nxt = {rad_nxt[RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = REM_W'(rem_t - trial);
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[REM_W-1:0];
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ITER);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tvs_dp.sv
// datapath: settings, velocity state, shared multiplier, divider, root and result word
`default_nettype none

module tvs_dp import tvs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tvs_in_t               in_word,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire tvs_cmd_t              cmd,
  output tvs_stat_t                  stat,
  output tvs_out_t                   out_word
);

  // settings
  logic [7:0] wait_ticks_r, ramp_ticks_r;
  logic [9:0] radius_r, lin_step_r, ang_step_r;

  // velocity state
  logic signed [15:0] lin_r, lin_nxt;
  logic signed [15:0] ang_r, ang_nxt;
  logic signed [15:0] origin_r, origin_nxt;
  logic signed [15:0] seen_lin_r, seen_lin_nxt;
  logic signed [15:0] seen_ang_r, seen_ang_nxt;
  logic [1:0]         gear_r, gear_nxt;
  logic               waiting_r, waiting_nxt;
  logic               ramping_r, ramping_nxt;
  logic [7:0]         idle_r, idle_nxt;
  logic [7:0]         rcount_r, rcount_nxt;

  // arithmetic
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    mul_p, mul_r, acc_r;
  logic [DIV_W-1:0]     div_dvd, div_quo;
  logic [DVS_W-1:0]     div_dvs;
  logic                 div_busy, sqrt_busy;
  logic [ROOT_W-1:0]    sqrt_root;
  logic [RAD_W-1:0]     sqrt_rad;
  logic [RND_SUM_W-1:0] rnd_sum;
  logic [RND_Y_W-1:0]   rnd_y;
  tvs_out_t             out_r;

  // step sums before clamping
  logic signed [17:0] lin_up, lin_dn, ang_up, ang_dn;
  logic [7:0]         idle_inc;
  logic [15:0]        ramp_q;
  logic signed [15:0] lin_sel, ang_sel;

  assign lin_up   = $signed({{2{lin_r[15]}}, lin_r}) + $signed({8'd0, lin_step_r});
  assign lin_dn   = $signed({{2{lin_r[15]}}, lin_r}) - $signed({8'd0, lin_step_r});
  assign ang_up   = $signed({{2{ang_r[15]}}, ang_r}) + $signed({8'd0, ang_step_r});
  assign ang_dn   = $signed({{2{ang_r[15]}}, ang_r}) - $signed({8'd0, ang_step_r});
  assign idle_inc = (idle_r == 8'hff) ? 8'hff : idle_r + 8'd1;
  assign ramp_q   = div_quo[15:0];

  // speed is taken from the commands in manual gear, else from the measured twist
  assign lin_sel = (gear_r == GEAR_MANUAL) ? lin_r : seen_lin_r;
  assign ang_sel = (gear_r == GEAR_MANUAL) ? ang_r : seen_ang_r;

  // state update for events, tick bookkeeping and ramp write-back
  always_comb begin
    lin_nxt      = lin_r;
    ang_nxt      = ang_r;
    origin_nxt   = origin_r;
    seen_lin_nxt = seen_lin_r;
    seen_ang_nxt = seen_ang_r;
    gear_nxt     = gear_r;
    waiting_nxt  = waiting_r;
    ramping_nxt  = ramping_r;
    idle_nxt     = idle_r;
    rcount_nxt   = rcount_r;
    if (cmd.accept) begin
      unique case (in_word.mode)
        MODE_MANUAL: begin
          if (gear_r != GEAR_AUTO) begin
            unique case (in_word.command_code) inside
              CMD_LIN_UP: lin_nxt = sat16(lin_up);
              CMD_LIN_DN: lin_nxt = sat16(lin_dn);
              CMD_ANG_DN, CMD_ANG_UP: begin
                ang_nxt     = (in_word.command_code == CMD_ANG_UP) ? sat16(ang_up)
                                                                   : sat16(ang_dn);
                waiting_nxt = 1'b1;
                ramping_nxt = 1'b0;
                idle_nxt    = '0;
              end
              CMD_ZERO: begin
                lin_nxt     = '0;
                ang_nxt     = '0;
                waiting_nxt = 1'b0;
                ramping_nxt = 1'b0;
              end
              default: ;
            endcase
          end
        end
        MODE_GEAR: gear_nxt = in_word.gear_value;
        MODE_PROC: begin
          if (in_word.process_busy) begin
            lin_nxt     = '0;
            ang_nxt     = '0;
            waiting_nxt = 1'b0;
            ramping_nxt = 1'b0;
          end
        end
        MODE_TWIST: begin
          seen_lin_nxt = in_word.measured_linear;
          seen_ang_nxt = in_word.measured_angular;
        end
        default: ;
      endcase
    end
    // idle count after an angular step, and the start of the decay
    if (cmd.tick_upd && waiting_r) begin
      idle_nxt = idle_inc;
      if (idle_inc >= wait_ticks_r) begin
        origin_nxt  = ang_r;
        rcount_nxt  = '0;
        ramping_nxt = 1'b1;
        waiting_nxt = 1'b0;
      end
    end
    if (cmd.ramp_zero) begin
      ang_nxt     = '0;
      ramping_nxt = 1'b0;
    end
    // quotient carries the magnitude, sign comes back from the ramp origin
    if (cmd.ramp_wb) begin
      ang_nxt    = origin_r[15] ? $signed(~ramp_q + 16'd1) : $signed(ramp_q);
      rcount_nxt = rcount_r + 8'd1;
    end
  end

  // settings and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r <= 8'd3;
      ramp_ticks_r <= 8'd8;
      radius_r     <= 10'd160;
      lin_step_r   <= 10'd10;
      ang_step_r   <= 10'd100;
      lin_r        <= '0;
      ang_r        <= '0;
      origin_r     <= '0;
      seen_lin_r   <= '0;
      seen_ang_r   <= '0;
      gear_r       <= GEAR_AUTO;
      waiting_r    <= 1'b0;
      ramping_r    <= 1'b0;
      idle_r       <= '0;
      rcount_r     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WAIT_TICKS:   wait_ticks_r <= cfg_wdata[7:0];
          CFG_RAMP_TICKS:   ramp_ticks_r <= cfg_wdata[7:0];
          CFG_RADIUS_MM:    radius_r     <= cfg_wdata;
          CFG_LINEAR_STEP:  lin_step_r   <= cfg_wdata;
          CFG_ANGULAR_STEP: ang_step_r   <= cfg_wdata;
          default: ;
        endcase
      end
      lin_r      <= lin_nxt;
      ang_r      <= ang_nxt;
      origin_r   <= origin_nxt;
      seen_lin_r <= seen_lin_nxt;
      seen_ang_r <= seen_ang_nxt;
      gear_r     <= gear_nxt;
      waiting_r  <= waiting_nxt;
      ramping_r  <= ramping_nxt;
      idle_r     <= idle_nxt;
      rcount_r   <= rcount_nxt;
    end
  end

  // root plus half a cm/s, divided by 16 ahead of the reciprocal multiply
  assign rnd_sum = {1'b0, sqrt_root} + RND_SUM_W'(K_HALF);
  assign rnd_y   = rnd_sum[RND_SUM_W-1:RND_SHIFT];

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_op)
      MUL_RAMP: begin
        mul_a = {9'd0, mag16(origin_r)};
        mul_b = {17'd0, ramp_ticks_r - rcount_r};
      end
      MUL_LIN: begin
        mul_a = {9'd0, mag16(lin_sel)};
        mul_b = MUL_W'(K_LIN);
      end
      MUL_ANG: begin
        mul_a = {9'd0, mag16(ang_sel)};
        mul_b = {15'd0, radius_r};
      end
      MUL_SQ: begin
        mul_a = mul_r[MUL_W-1:0];
        mul_b = mul_r[MUL_W-1:0];
      end
      MUL_RND: begin
        mul_a = {2'd0, rnd_y};
        mul_b = MUL_W'(RND_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product register and the register that holds the first square
  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      mul_r <= mul_p;
    end
    if (cmd.acc_load) begin
      acc_r <= mul_r;
    end
  end

  // divider serves the ramp
  assign div_dvd = mul_r[DIV_W-1:0];
  assign div_dvs = {6'd0, ramp_ticks_r};

  assign sqrt_rad = RAD_W'(acc_r) + RAD_W'(mul_r);

  tvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  tvs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sqrt_rad),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  // result word, speed taken from the top of the reciprocal product
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.linear_cmd    <= lin_r;
      out_r.angular_cmd   <= ang_r;
      out_r.publish_twist <= (gear_r == GEAR_MANUAL);
      out_r.speed_cms     <= (mul_r[PROD_W-1:RND_POS] > SPD_HI_W'(SPEED_MAX))
                             ? SPEED_W'(SPEED_MAX) : mul_r[RND_POS +: SPEED_W];
    end
  end

  assign out_word       = out_r;
  assign stat.in_tick   = (in_word.mode == MODE_TICK);
  assign stat.ramping   = ramping_r;
  assign stat.ramp_end  = (rcount_r >= ramp_ticks_r);
  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sqrt_busy;

endmodule

`default_nettype wire

FILE: hw/rtl/tvs_ctrl.sv
// controller: sequences a tick through ramp, speed and result word
`default_nettype none

module tvs_ctrl import tvs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire tvs_stat_t stat,
  output tvs_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd.accept     = 1'b0;
    cmd.tick_upd   = 1'b0;
    cmd.ramp_zero  = 1'b0;
    cmd.ramp_wb    = 1'b0;
    cmd.mul_op     = MUL_NONE;
    cmd.acc_load   = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.sqrt_start = 1'b0;
    cmd.emit       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_tick) begin
            state_nxt = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        cmd.tick_upd = 1'b1;
        state_nxt    = ST_RAMP;
      end
      ST_RAMP: begin
        if (!stat.ramping) begin
          state_nxt = ST_SLIN;
        end else if (stat.ramp_end) begin
          cmd.ramp_zero = 1'b1;
          state_nxt     = ST_SLIN;
        end else begin
          state_nxt = ST_RMUL;
        end
      end
      ST_RMUL: begin
        cmd.mul_op = MUL_RAMP;
        state_nxt  = ST_RDIV_GO;
      end
      ST_RDIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_RDIV;
      end
      ST_RDIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_RWB;
        end
      end
      ST_RWB: begin
        cmd.ramp_wb = 1'b1;
        state_nxt   = ST_SLIN;
      end
      ST_SLIN: begin
        cmd.mul_op = MUL_LIN;
        state_nxt  = ST_SLSQ;
      end
      ST_SLSQ: begin
        cmd.mul_op = MUL_SQ;
        state_nxt  = ST_SANG;
      end
      ST_SANG: begin
        cmd.mul_op   = MUL_ANG;
        cmd.acc_load = 1'b1;
        state_nxt    = ST_SASQ;
      end
      ST_SASQ: begin
        cmd.mul_op = MUL_SQ;
        state_nxt  = ST_SQRT_GO;
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_SQRT;
      end
      ST_SQRT: begin
        if (!stat.sqrt_busy) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        cmd.mul_op = MUL_RND;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result word holding register flag
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/teleop_velocity_shaper.sv
// events other than ticks are taken from idle and update the state registers, staying idle
// a tick runs the tick update, the ramp multiply and divide while ramping, the speed
// squares, root and rounding multiply, and holds off input until its result word is registered
// a result word waiting to be taken does not block the next input word
// reset: synchronous active-low, clears state and restores the default settings
`default_nettype none

module teleop_velocity_shaper import tvs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tvs_in_t               in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tvs_out_t                   out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  tvs_cmd_t  cmd;
  tvs_stat_t stat;

  // settings writes always land at once
  assign cfg_ready = 1'b1;

  tvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tvs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tvs_chk.sv
// port checker for the teleop velocity shaper and its bind
`default_nettype none

module tvs_chk import tvs_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire tvs_in_t  in_word,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire tvs_out_t out_word
);

  // no result word straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // an accepted tick occupies the block for the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.mode == MODE_TICK) |=> in_stall)
    else $error("input taken straight after a tick");

  // events other than ticks never make a result word
  a_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.mode != MODE_TICK) && !out_valid |=> !out_valid)
    else $error("result word after a non-tick event");

endmodule

bind teleop_velocity_shaper tvs_chk u_tvs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
